// ===== rtl/adsr_envelope_echo_macros.svh =====
// Assertion macros shared by the envelope echo block.
`ifndef ADSR_ENVELOPE_ECHO_MACROS_SVH
`define ADSR_ENVELOPE_ECHO_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/aee_pkg.sv =====
// Shared types and constants of the envelope echo block.
package aee_pkg;

   localparam int CHANNELS_DEFAULT = 12;
   localparam int CHANNEL_W = 4;

   localparam logic [3:0] MASTER_VOLUME_RESET = 4'd15;
   localparam logic [7:0] LEVEL_MAX = 8'd255;

   localparam logic [1:0] FUNC_KEY_ON  = 2'd0;
   localparam logic [1:0] FUNC_KEY_OFF = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;

   typedef enum logic [2:0] {
      PH_OFF,
      PH_START,
      PH_ATTACK,
      PH_DECAY,
      PH_SUSTAIN,
      PH_ECHO
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       release_flag;
      logic [7:0] level;
      logic [7:0] countdown;
   } chan_state_type;

   localparam chan_state_type CHAN_STATE_RESET = '{
      phase:        PH_OFF,
      release_flag: 1'b0,
      level:        8'd0,
      countdown:    8'd0
   };

   typedef struct packed {
      logic [7:0] echo_level;
      logic [7:0] release_factor;
      logic [7:0] sustain_level;
      logic [7:0] decay_factor;
      logic [7:0] attack_step;
   } note_params_type;

   typedef struct packed {
      logic           wr_state;
      logic           wr_params;
      logic           emit;
      logic           live;
      logic [7:0]     env_level;
      chan_state_type next;
   } calc_result_type;

endpackage

// ===== rtl/aee_ram.sv =====
// Generic single-port-write, registered-read RAM.
module aee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/aee_env_calc.sv =====
// Next channel state for one item: key on, key off or one envelope tick.
module aee_env_calc
   import aee_pkg::*;
(
   input  logic            [1:0] func,
   input  logic                  ch_ok,
   input  chan_state_type        cur,
   input  note_params_type       params,
   input  logic            [7:0] echo_length,
   output calc_result_type       result
);

   logic [7:0]  factor;
   logic [15:0] product;

   assign factor  = cur.release_flag ? params.release_factor : params.decay_factor;
   assign product = 16'(cur.level) * 16'(factor);

   always_comb begin
      calc_result_type res;
      logic [7:0]      env;
      logic [8:0]      attack_sum;
      logic            live;

      res        = '0;
      res.next   = cur;
      env        = cur.level;
      live       = 1'b1;
      attack_sum = '0;

      if (ch_ok) begin
         unique case (func)
            FUNC_KEY_ON: begin
               res.wr_params         = 1'b1;
               res.wr_state          = 1'b1;
               res.next.phase        = PH_START;
               res.next.release_flag = 1'b0;
               res.next.countdown    = echo_length;
            end
            FUNC_KEY_OFF: begin
               if (cur.phase != PH_OFF) begin
                  res.wr_state          = 1'b1;
                  res.next.release_flag = 1'b1;
               end
            end
            FUNC_TICK: begin
               if (cur.phase != PH_OFF) begin
                  res.wr_state = 1'b1;
                  res.emit     = 1'b1;
                  case (cur.phase) inside
                     PH_START: begin
                        if (cur.release_flag) begin
                           live = 1'b0;
                        end else begin
                           res.next.phase = PH_ATTACK;
                           env            = '0;
                        end
                     end
                     PH_ECHO: begin
                        res.next.countdown = cur.countdown - 8'd1;
                        if (res.next.countdown == '0) begin
                           live = 1'b0;
                        end
                     end
                     PH_ATTACK, PH_DECAY, PH_SUSTAIN: begin
                        if (cur.release_flag) begin
                           env = product[15:8];
                           if (env <= params.echo_level) begin
                              if (params.echo_level == '0) begin
                                 live = 1'b0;
                              end else begin
                                 env            = params.echo_level;
                                 res.next.phase = PH_ECHO;
                              end
                           end
                        end else if (cur.phase == PH_DECAY) begin
                           env = product[15:8];
                           if (env <= params.sustain_level) begin
                              env = params.sustain_level;
                              if (params.sustain_level != '0) begin
                                 res.next.phase = PH_SUSTAIN;
                              end else if (params.echo_level == '0) begin
                                 live = 1'b0;
                              end else begin
                                 env            = params.echo_level;
                                 res.next.phase = PH_ECHO;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase

                  // Attack adds and saturates instead of wrapping.
                  attack_sum = {1'b0, env} + {1'b0, params.attack_step};
                  if (live && res.next.phase == PH_ATTACK && !cur.release_flag) begin
                     if (attack_sum >= {1'b0, LEVEL_MAX}) begin
                        env            = LEVEL_MAX;
                        res.next.phase = PH_DECAY;
                     end else begin
                        env = attack_sum[7:0];
                     end
                  end

                  if (live) begin
                     res.next.level = env;
                  end else begin
                     res.next.phase        = PH_OFF;
                     res.next.release_flag = 1'b0;
                     env                   = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      res.live      = live;
      res.env_level = env;
      result        = res;
   end

endmodule

// ===== rtl/aee_level_mix.sv =====
// Master volume scaling and left/right pan products of the envelope level.
module aee_level_mix (
   input  logic       clock,
   input  logic       load,
   input  logic [3:0] master_volume,
   input  logic [7:0] env_level,
   input  logic [7:0] right_volume,
   input  logic [7:0] left_volume,
   output logic [7:0] right_level,
   output logic [7:0] left_level
);

   logic [12:0] scaled_full;
   logic [7:0]  scaled_ff;
   logic [15:0] right_prod;
   logic [15:0] left_prod;

   // (volume + 1) * level >> 4 never exceeds 255.
   assign scaled_full = (13'({1'b0, master_volume}) + 13'd1) * 13'(env_level);

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_ff <= scaled_full[11:4];
      end
   end

   // Top byte of an 8x8 product stays below 255, so no clamp is needed.
   assign right_prod  = 16'(right_volume) * 16'(scaled_ff);
   assign left_prod   = 16'(left_volume) * 16'(scaled_ff);
   assign right_level = right_prod[15:8];
   assign left_level  = left_prod[15:8];

endmodule

// ===== rtl/adsr_envelope_echo.sv =====
// Multi-channel ADSR envelope generator with an echo tail.
// Input channel (req_*): one item per handshake. func selects key on (store the
// note parameters and mark a start), key off (set release on a sounding channel)
// or tick (advance that channel's envelope once). Items for a channel at or
// beyond CHANNELS, and unknown func codes, are taken and dropped.
// Result channel (rsp_*): one item per tick on a sounding channel, carrying the
// envelope level and the left/right levels scaled by master volume.
// csr_write_data loads master volume whenever csr_write_enable is high.
// Per-channel state sits in a registered-read RAM, read as an item is accepted;
// the item is then modified and written back in ST_CALC, after which key on and
// key off are done. A tick then passes ST_SCALE and ST_MIX for the volume and pan
// multipliers, its result is loaded into the output register from ST_MIX, and the
// next item is taken only after that.
// A finished result waits in the output register; while the receiver stalls a
// following key on or key off still completes, and a following tick holds in its
// last stage until the output register frees.
// Reset clears master volume to 15 and marks every channel silent at once.
`include "adsr_envelope_echo_macros.svh"

module adsr_envelope_echo
   import aee_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  logic [CHANNEL_W-1:0] req_channel,
   input  logic [7:0]           req_attack_step,
   input  logic [7:0]           req_decay_factor,
   input  logic [7:0]           req_sustain_level,
   input  logic [7:0]           req_release_factor,
   input  logic [7:0]           req_echo_level,
   input  logic [7:0]           req_echo_length,
   input  logic [7:0]           req_right_volume,
   input  logic [7:0]           req_left_volume,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHANNEL_W-1:0] rsp_out_channel,
   output logic                 rsp_active,
   output logic [7:0]           rsp_envelope_level,
   output logic [7:0]           rsp_right_level,
   output logic [7:0]           rsp_left_level,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data
);

   localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STATE_W = $bits(chan_state_type);
   localparam int PARAM_W = $bits(note_params_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_SCALE,
      ST_MIX
   } state_type;

   state_type state_ff, state_in;

   logic                 req_accept;
   logic                 req_ch_ok;
   logic [ADDR_W-1:0]    req_idx;

   logic [3:0]           master_volume_ff;
   logic [CHANNELS-1:0]  valid_ff;

   logic [1:0]           func_ff;
   logic                 ch_ok_ff;
   logic [ADDR_W-1:0]    idx_ff;
   logic [CHANNEL_W-1:0] channel_ff;
   note_params_type      item_params_ff;
   logic [7:0]           echo_length_ff;
   logic [7:0]           right_volume_ff;
   logic [7:0]           left_volume_ff;
   logic                 active_ff;
   logic [7:0]           env_ff;

   logic [STATE_W-1:0]   state_rd;
   logic [PARAM_W-1:0]   params_rd;
   chan_state_type       cur;
   calc_result_type      calc;
   logic                 st_wr_en;
   logic                 par_wr_en;

   logic                 mix_load;
   logic                 load_out;
   logic [7:0]           mix_right;
   logic [7:0]           mix_left;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   logic                 rsp_active_ff;
   logic [7:0]           rsp_env_ff;
   logic [7:0]           rsp_right_ff;
   logic [7:0]           rsp_left_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign req_ch_ok  = ({1'b0, req_channel} < (CHANNEL_W + 1)'(CHANNELS));
   assign req_idx    = req_ch_ok ? ADDR_W'(req_channel) : '0;

   aee_ram #(
      .WIDTH (STATE_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (idx_ff),
      .wr_data (STATE_W'(calc.next)),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (state_rd)
   );

   aee_ram #(
      .WIDTH (PARAM_W),
      .DEPTH (CHANNELS)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (idx_ff),
      .wr_data (PARAM_W'(item_params_ff)),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (params_rd)
   );

   // A channel never written since reset reads as silent.
   assign cur = valid_ff[idx_ff] ? chan_state_type'(state_rd) : CHAN_STATE_RESET;

   aee_env_calc u_env_calc (
      .func        (func_ff),
      .ch_ok       (ch_ok_ff),
      .cur         (cur),
      .params      (note_params_type'(params_rd)),
      .echo_length (echo_length_ff),
      .result      (calc)
   );

   assign st_wr_en  = (state_ff == ST_CALC) && calc.wr_state;
   assign par_wr_en = (state_ff == ST_CALC) && calc.wr_params;

   aee_level_mix u_level_mix (
      .clock         (clock),
      .load          (mix_load),
      .master_volume (master_volume_ff),
      .env_level     (env_ff),
      .right_volume  (right_volume_ff),
      .left_volume   (left_volume_ff),
      .right_level   (mix_right),
      .left_level    (mix_left)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_ff <= MASTER_VOLUME_RESET;
         valid_ff         <= '0;
      end else begin
         if (csr_write_enable) begin
            master_volume_ff <= csr_write_data;
         end
         if (st_wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Capture the item on accept; hold the tick outcome for the mix stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff                       <= req_func;
         ch_ok_ff                      <= req_ch_ok;
         idx_ff                        <= req_idx;
         channel_ff                    <= req_channel;
         item_params_ff.attack_step    <= req_attack_step;
         item_params_ff.decay_factor   <= req_decay_factor;
         item_params_ff.sustain_level  <= req_sustain_level;
         item_params_ff.release_factor <= req_release_factor;
         item_params_ff.echo_level     <= req_echo_level;
         echo_length_ff                <= req_echo_length;
         right_volume_ff               <= req_right_volume;
         left_volume_ff                <= req_left_volume;
      end
      if (state_ff == ST_CALC) begin
         active_ff <= calc.live;
         env_ff    <= calc.env_level;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mix_load     = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = calc.emit ? ST_SCALE : ST_IDLE;
         end
         ST_SCALE: begin
            mix_load = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         rsp_channel_ff <= channel_ff;
         rsp_active_ff  <= active_ff;
         rsp_env_ff     <= env_ff;
         rsp_right_ff   <= mix_right;
         rsp_left_ff    <= mix_left;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_active         = rsp_active_ff;
   assign rsp_envelope_level = rsp_env_ff;
   assign rsp_right_level    = rsp_right_ff;
   assign rsp_left_level     = rsp_left_ff;

   `AEE_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && req_ready,
      state_ff == ST_CALC, "accepted item did not move to the write-back cycle")
   `AEE_ASSERT_SAME(a_rsp_from_mix, clock, reset, $rose(rsp_valid),
      $past(state_ff == ST_MIX), "result appeared without passing the mix stage")
   `AEE_ASSERT_SAME(a_silent_zero, clock, reset, rsp_valid && !rsp_active,
      (rsp_envelope_level == 8'd0) && (rsp_right_level == 8'd0) &&
      (rsp_left_level == 8'd0), "silenced channel returned nonzero levels")

endmodule
